[hdl/status_led_pattern_sequencer_core_assert.svh]
// Assertion macros shared by the status LED sequencer RTL.
`ifndef STATUS_LED_PATTERN_SEQUENCER_CORE_ASSERT_SVH
`define STATUS_LED_PATTERN_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("slps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("slps assertion failed");

`endif

[hdl/slps_pkg.sv]
// Package: state codes, pattern constants and helper functions for the LED sequencer.
`default_nettype none

package slps_pkg;

	localparam int unsigned MODE_W  = 4;
	localparam int unsigned PHASE_W = 6;
	localparam int unsigned HOLD_W  = 8;
	localparam int unsigned CHAN_W  = 8;

	localparam logic [MODE_W-1:0] MODE_BOOTING      = 4'd0;
	localparam logic [MODE_W-1:0] MODE_CHECK_PROV   = 4'd1;
	localparam logic [MODE_W-1:0] MODE_NOT_PROV     = 4'd2;
	localparam logic [MODE_W-1:0] MODE_PROV_START   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_PROVISIONING = 4'd4;
	localparam logic [MODE_W-1:0] MODE_PROV_SUCCESS = 4'd5;
	localparam logic [MODE_W-1:0] MODE_WIFI_CONN    = 4'd6;
	localparam logic [MODE_W-1:0] MODE_GOT_IP       = 4'd7;
	localparam logic [MODE_W-1:0] MODE_MQTT_CONN    = 4'd8;
	localparam logic [MODE_W-1:0] MODE_RUNNING      = 4'd9;
	localparam logic [MODE_W-1:0] MODE_RECONNECTING = 4'd10;
	localparam logic [MODE_W-1:0] MODE_ERROR        = 4'd11;

	localparam logic KIND_STATE_WRITE = 1'b0;
	localparam logic KIND_TICK        = 1'b1;

	// Phase runs over one 3 s period of 50 ms ticks.
	localparam int unsigned PHASE_WRAP = 3000 / 50;
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_WRAP - 1);
	localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_W'(PHASE_WRAP / 2);
	localparam logic [PHASE_W-1:0] PHASE_FULL = PHASE_W'(PHASE_WRAP);

	localparam logic [HOLD_W-1:0] HOLD_MAX      = 8'd255;
	localparam logic [HOLD_W-1:0] LONG_PRESS_RST = 8'd60;

	localparam logic [CHAN_W-1:0] CH_FULL = 8'd255;
	localparam logic [CHAN_W-1:0] CH_HALF = 8'd128;
	localparam logic [CHAN_W-1:0] CH_OFF  = 8'd0;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

	localparam rgb_t RGB_BLACK  = '{r: CH_OFF,  g: CH_OFF,  b: CH_OFF};
	localparam rgb_t RGB_WHITE  = '{r: CH_FULL, g: CH_FULL, b: CH_FULL};
	localparam rgb_t RGB_RED    = '{r: CH_FULL, g: CH_OFF,  b: CH_OFF};
	localparam rgb_t RGB_GREEN  = '{r: CH_OFF,  g: CH_FULL, b: CH_OFF};
	localparam rgb_t RGB_BLUE   = '{r: CH_OFF,  g: CH_OFF,  b: CH_FULL};
	localparam rgb_t RGB_YELLOW = '{r: CH_FULL, g: CH_FULL, b: CH_OFF};
	localparam rgb_t RGB_CYAN   = '{r: CH_OFF,  g: CH_FULL, b: CH_FULL};
	localparam rgb_t RGB_ORANGE = '{r: CH_FULL, g: CH_HALF, b: CH_OFF};

	// First half of a 10-tick period (phase mod 10 < 5).
	function automatic logic blink10_on(input logic [PHASE_W-1:0] p);
		blink10_on = p inside {[6'd0:6'd4], [6'd10:6'd14], [6'd20:6'd24],
			[6'd30:6'd34], [6'd40:6'd44], [6'd50:6'd54]};
	endfunction

	// First half of a 20-tick period (phase mod 20 < 10).
	function automatic logic blink20_on(input logic [PHASE_W-1:0] p);
		blink20_on = p inside {[6'd0:6'd9], [6'd20:6'd29], [6'd40:6'd49]};
	endfunction

endpackage

`default_nettype wire

[hdl/slps_pattern.sv]
// Per-state LED colour pattern: steady colours, square blinks and the breath ramp.
`default_nettype none

module slps_pattern
	import slps_pkg::*;
(
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic [PHASE_W-1:0] phase,
	output logic                    drive,
	output rgb_t                    colour
);

	logic [4:0] ramp_x;
	logic [9:0] ramp_prod;
	logic [CHAN_W-1:0] breath;
	logic [PHASE_W-1:0] ramp_down;

	// Breath level is x*255/30 = x*17/2, x folded around the half period.
	always_comb begin
		ramp_down = PHASE_FULL - phase;
		ramp_x    = (phase < PHASE_HALF) ? phase[4:0] : ramp_down[4:0];
		ramp_prod = {5'd0, ramp_x} * 10'd17;
		breath    = ramp_prod[8:1];
	end

	always_comb begin
		drive  = (mode != MODE_RUNNING);
		colour = RGB_BLACK;
		case (mode)
			MODE_BOOTING:      colour = !phase[1] ? RGB_WHITE : RGB_BLACK;
			MODE_CHECK_PROV:   colour = RGB_WHITE;
			MODE_NOT_PROV:     colour = blink20_on(phase) ? RGB_BLUE : RGB_BLACK;
			MODE_PROV_START:   colour = !phase[1] ? RGB_BLUE : RGB_BLACK;
			MODE_PROVISIONING: colour = '{r: CH_OFF, g: CH_OFF, b: breath};
			MODE_PROV_SUCCESS: colour = !phase[1] ? RGB_GREEN : RGB_BLACK;
			MODE_WIFI_CONN:    colour = blink10_on(phase) ? RGB_YELLOW : RGB_BLACK;
			MODE_GOT_IP:       colour = RGB_GREEN;
			MODE_MQTT_CONN:    colour = blink10_on(phase) ? RGB_CYAN : RGB_BLACK;
			MODE_RECONNECTING: colour = blink10_on(phase) ? RGB_ORANGE : RGB_BLACK;
			MODE_ERROR:        colour = !phase[0] ? RGB_RED : RGB_BLACK;
			default:           colour = RGB_BLACK;
		endcase
	end

endmodule

`default_nettype wire

[hdl/status_led_pattern_sequencer_core.sv]
// Top level of the status LED pattern sequencer.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one transaction per item: kind 0 writes
//    the system state from target_state (codes 12..15 are dropped), kind 1 is a 50 ms
//    tick that carries the reset button level.
//  - Only a tick produces a result transaction on the output channel (out_valid/out_ready):
//    led_drive, red/green/blue, start_mqtt, reset_request and sys_state.
//  - A tick's result is captured in the result register when the tick is accepted.
//  - Throughput: one transaction per cycle while in_ready is high; all per-tick logic sits
//    between the state registers and the single result register.
//  - Stall: while a result waits, in_ready stays high only if out_ready is high in the
//    same cycle; state writes still pass when the result register is free or draining.
//  - Reset (arst_n low): state booting, phase and hold counters zero, long_press_ticks 60,
//    no result pending.
//  - cfg_we/cfg_wdata write long_press_ticks on any edge; intended only while idle.
//  - A threshold of 0 behaves like 1.
`default_nettype none

module status_led_pattern_sequencer_core
	import slps_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_we,
	input  wire logic [HOLD_W-1:0]  cfg_wdata,

	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic [MODE_W-1:0]  target_state,
	input  wire logic               button_level,

	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    led_drive,
	output logic [CHAN_W-1:0]       red,
	output logic [CHAN_W-1:0]       green,
	output logic [CHAN_W-1:0]       blue,
	output logic                    start_mqtt,
	output logic                    reset_request,
	output logic [MODE_W-1:0]       sys_state
);

	// Architectural state
	logic [MODE_W-1:0]  mode_q;
	logic [PHASE_W-1:0] phase_q;
	logic [HOLD_W-1:0]  hold_q;
	logic [HOLD_W-1:0]  long_press_q;

	// Result register
	logic               out_valid_q;
	logic               drive_q;
	rgb_t               colour_q;
	logic               start_q;
	logic               rst_req_q;
	logic [MODE_W-1:0]  state_q;

	logic in_fire;
	logic tick_fire;
	logic write_fire;

	logic [MODE_W-1:0]  mode_eff;
	logic               got_ip_adv;
	logic               pat_drive;
	rgb_t               pat_colour;
	logic [HOLD_W-1:0]  hold_next;
	logic [HOLD_W-1:0]  threshold;
	logic               long_press;
	logic [PHASE_W-1:0] phase_next;
	logic               drive_next;
	rgb_t               colour_next;

	// Output colour shorthands for the checks
	logic               out_black;
	logic               out_red;

	// Result register frees up when empty or being drained this cycle.
	assign in_ready   = !out_valid_q || out_ready;
	assign in_fire    = in_valid && in_ready;
	assign tick_fire  = in_fire && (kind == KIND_TICK);
	assign write_fire = in_fire && (kind == KIND_STATE_WRITE);

	// Got-IP auto-advances to MQTT connecting before the pattern is chosen.
	assign got_ip_adv = (mode_q == MODE_GOT_IP);
	assign mode_eff   = got_ip_adv ? MODE_MQTT_CONN : mode_q;

	slps_pattern u_pattern (
		.mode   (mode_eff),
		.phase  (phase_q),
		.drive  (pat_drive),
		.colour (pat_colour)
	);

	// Button hold counter: saturating, cleared on release.
	always_comb begin
		if (!button_level) begin
			hold_next = '0;
		end else if (hold_q == HOLD_MAX) begin
			hold_next = HOLD_MAX;
		end else begin
			hold_next = hold_q + HOLD_W'(1);
		end
		threshold  = (long_press_q == '0) ? HOLD_W'(1) : long_press_q;
		long_press = button_level && (hold_next >= threshold);
	end

	// Long press overrides whatever the pattern shows, including running.
	always_comb begin
		drive_next  = pat_drive;
		colour_next = pat_drive ? pat_colour : RGB_BLACK;
		if (long_press) begin
			drive_next  = 1'b1;
			colour_next = RGB_RED;
		end
	end

	assign phase_next = (phase_q == PHASE_LAST) ? '0 : phase_q + PHASE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_BOOTING;
			phase_q      <= '0;
			hold_q       <= '0;
			long_press_q <= LONG_PRESS_RST;
		end else begin
			if (cfg_we) begin
				long_press_q <= cfg_wdata;
			end
			if (write_fire && (target_state <= MODE_ERROR)) begin
				mode_q <= target_state;
			end else if (tick_fire) begin
				mode_q <= mode_eff;
			end
			if (tick_fire) begin
				phase_q <= phase_next;
				hold_q  <= hold_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			drive_q   <= drive_next;
			colour_q  <= colour_next;
			start_q   <= got_ip_adv;
			rst_req_q <= long_press;
			state_q   <= mode_eff;
		end
	end

	assign out_valid     = out_valid_q;
	assign led_drive     = drive_q;
	assign red           = colour_q.r;
	assign green         = colour_q.g;
	assign blue          = colour_q.b;
	assign start_mqtt    = start_q;
	assign reset_request = rst_req_q;
	assign sys_state     = state_q;

	// Checks
	assign out_black = (red == CH_OFF) && (green == CH_OFF) && (blue == CH_OFF);
	assign out_red   = (red == CH_FULL) && (green == CH_OFF) && (blue == CH_OFF);

`include "status_led_pattern_sequencer_core_assert.svh"

	`SLPS_ASSERT_NOW(a_phase_range, clk, arst_n, 1'b1, phase_q <= PHASE_LAST)
	`SLPS_ASSERT_NEXT(a_write_keeps_phase, clk, arst_n, write_fire, $stable(phase_q) && $stable(hold_q))
	`SLPS_ASSERT_NOW(a_reset_shows_red, clk, arst_n, out_valid && reset_request, led_drive && out_red)
	`SLPS_ASSERT_NOW(a_start_in_mqtt, clk, arst_n, out_valid && start_mqtt, sys_state == MODE_MQTT_CONN)
	`SLPS_ASSERT_NOW(a_undriven_black, clk, arst_n, out_valid && !led_drive, (sys_state == MODE_RUNNING) && out_black)

endmodule

`default_nettype wire

[tb/status_led_pattern_sequencer_core_tb.sv]
// Self-checking testbench for the status LED pattern sequencer core.
`timescale 1ns / 1ps
`default_nettype none

module status_led_pattern_sequencer_core_tb;
	import slps_pkg::*;

	// Cycles without any transaction before the run is declared hung. The slowest
	// legal stretch is the deliberate receiver hold-off below plus a long random gap.
	localparam int unsigned STALL_LIMIT   = 2000;
	// An accepted transaction is reflected once it is registered; allow a little slack.
	localparam int unsigned SETTLE_CYCLES = 2;
	localparam int unsigned TAIL_CYCLES   = 4;
	localparam int unsigned HOLDOFF_LEN   = 150;

	// One expected or observed tick result.
	typedef struct packed {
		logic              led_drive;
		rgb_t              color;
		logic              start_mqtt;
		logic              reset_request;
		logic [MODE_W-1:0] state;
	} led_frame_t;

	// Scoreboard: tracks the sequencer state, predicts each tick result and
	// matches the results coming out of the block in order.
	class led_sequence_checker;
		logic [MODE_W-1:0]  mode;
		logic [PHASE_W-1:0] phase;
		logic [HOLD_W-1:0]  hold;
		logic [HOLD_W-1:0]  threshold;
		led_frame_t         pending_frames[$];
		int unsigned        mismatches;

		function new();
			mode = MODE_BOOTING;
			phase = '0;
			hold = '0;
			threshold = LONG_PRESS_RST;
			mismatches = 0;
		endfunction

		function void set_threshold(input logic [HOLD_W-1:0] value);
			threshold = value;
		endfunction

		function int unsigned outstanding();
			return pending_frames.size();
		endfunction

		// Color the current mode shows at the current phase.
		function rgb_t pattern_color();
			int unsigned period;
			int unsigned p;
			int unsigned level;
			rgb_t on_color;
			rgb_t c;
			p = phase;
			period = 1;
			on_color = RGB_BLACK;
			c = RGB_BLACK;
			case (mode)
				MODE_BOOTING: begin
					period = 4;
					on_color = RGB_WHITE;
				end
				MODE_CHECK_PROV: return RGB_WHITE;
				MODE_NOT_PROV: begin
					period = 20;
					on_color = RGB_BLUE;
				end
				MODE_PROV_START: begin
					period = 4;
					on_color = RGB_BLUE;
				end
				MODE_PROVISIONING: begin
					// triangle over the 60-tick period, peak at phase 30
					level = (p < 30) ? (p * 255 / 30) : ((60 - p) * 255 / 30);
					c.b = level[CHAN_W-1:0];
					return c;
				end
				MODE_PROV_SUCCESS: begin
					period = 4;
					on_color = RGB_GREEN;
				end
				MODE_WIFI_CONN: begin
					period = 10;
					on_color = RGB_YELLOW;
				end
				MODE_GOT_IP: return RGB_GREEN;
				MODE_MQTT_CONN: begin
					period = 10;
					on_color = RGB_CYAN;
				end
				MODE_RECONNECTING: begin
					period = 10;
					on_color = RGB_ORANGE;
				end
				MODE_ERROR: begin
					period = 2;
					on_color = RGB_RED;
				end
				default: return RGB_BLACK;
			endcase
			return ((p % period) < (period / 2)) ? on_color : RGB_BLACK;
		endfunction

		function void note_item(input logic k, input logic [MODE_W-1:0] ns, input logic btn);
			led_frame_t f;
			logic [HOLD_W-1:0] limit;
			if (k == KIND_STATE_WRITE) begin
				// codes past the error state are dropped
				if (ns <= MODE_ERROR)
					mode = ns;
				return;
			end
			f.start_mqtt = 1'b0;
			f.reset_request = 1'b0;
			if (mode == MODE_GOT_IP) begin
				mode = MODE_MQTT_CONN;
				f.start_mqtt = 1'b1;
			end
			f.led_drive = (mode != MODE_RUNNING);
			f.color = f.led_drive ? pattern_color() : RGB_BLACK;
			if (btn) begin
				if (hold != HOLD_MAX)
					hold = hold + 1'b1;
				limit = (threshold == '0) ? 8'd1 : threshold;
				if (hold >= limit) begin
					f.reset_request = 1'b1;
					f.led_drive = 1'b1;
					f.color = RGB_RED;
				end
			end else begin
				hold = '0;
			end
			phase = (phase == PHASE_LAST) ? '0 : phase + 1'b1;
			f.state = mode;
			pending_frames.push_back(f);
		endfunction

		function void compare_field(input string name, input logic [7:0] e, input logic [7:0] a);
			if (e !== a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				mismatches++;
			end
		endfunction

		function void check_result(input led_frame_t got);
			led_frame_t e;
			if (pending_frames.size() == 0) begin
				$error("result with no tick outstanding: state %0d", got.state);
				mismatches++;
				return;
			end
			e = pending_frames.pop_front();
			compare_field("led_drive", 8'(e.led_drive), 8'(got.led_drive));
			compare_field("red", e.color.r, got.color.r);
			compare_field("green", e.color.g, got.color.g);
			compare_field("blue", e.color.b, got.color.b);
			compare_field("start_mqtt", 8'(e.start_mqtt), 8'(got.start_mqtt));
			compare_field("reset_request", 8'(e.reset_request), 8'(got.reset_request));
			compare_field("sys_state", 8'(e.state), 8'(got.state));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               cfg_we = 1'b0;
	logic [HOLD_W-1:0]  cfg_wdata = '0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               kind = KIND_TICK;
	logic [MODE_W-1:0]  target_state = MODE_BOOTING;
	logic               button_level = 1'b0;

	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               led_drive;
	logic [CHAN_W-1:0]  red;
	logic [CHAN_W-1:0]  green;
	logic [CHAN_W-1:0]  blue;
	logic               start_mqtt;
	logic               reset_request;
	logic [MODE_W-1:0]  sys_state;

	led_sequence_checker led_check = new();

	// Idle percentages of the two sides, changed between phases.
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_idle_pct = 0;
	// Nonzero asks the receiver process for a hold-off of that many cycles.
	int unsigned rx_hold_request = 0;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	// Mirror of the programmed threshold, used to size button holds.
	logic [HOLD_W-1:0] press_limit = LONG_PRESS_RST;

	always #1 clk = ~clk;

	status_led_pattern_sequencer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.target_state(target_state),
		.button_level(button_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_drive(led_drive),
		.red(red),
		.green(green),
		.blue(blue),
		.start_mqtt(start_mqtt),
		.reset_request(reset_request),
		.sys_state(sys_state)
	);

	// Monitor: both channels sampled at the edge. An input transaction is noted
	// before the output is checked; a tick's result cannot show on its own edge.
	always @(posedge clk) begin
		led_frame_t got;
		if (arst_n) begin
			if (in_valid && in_ready)
				led_check.note_item(kind, target_state, button_level);
			if (out_valid && out_ready) begin
				got.led_drive = led_drive;
				got.color.r = red;
				got.color.g = green;
				got.color.b = blue;
				got.start_mqtt = start_mqtt;
				got.reset_request = reset_request;
				got.state = sys_state;
				led_check.check_result(got);
			end
		end
	end

	// Watchdog: any transaction on either side resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("** status_led_pattern_sequencer_core: FAILED **");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure, or a long hold-off on request so the
	// result register fills and the input side stalls.
	initial begin
		int unsigned holdoff;
		forever begin
			@(posedge clk);
			if (rx_hold_request != 0) begin
				holdoff = rx_hold_request;
				rx_hold_request = 0;
				out_ready <= 1'b0;
				repeat (holdoff) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// One input transaction, preceded by random idle cycles. Returns at the
	// edge that accepted it, with valid still high.
	task automatic send_item(input logic k, input logic [MODE_W-1:0] ns, input logic btn);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		target_state <= ns;
		button_level <= btn;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_state(input logic [MODE_W-1:0] ns);
		send_item(KIND_STATE_WRITE, ns, 1'($urandom_range(1)));
	endtask

	task automatic send_tick(input logic btn);
		send_item(KIND_TICK, MODE_W'($urandom_range(15)), btn);
	endtask

	// Button held for a number of ticks, then released.
	task automatic hold_button(input int unsigned ticks);
		repeat (ticks) send_tick(1'b1);
		send_tick(1'b0);
	endtask

	// Stop offering and wait until every tick result has been taken.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (led_check.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [HOLD_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		press_limit = value;
		led_check.set_threshold(value);
	endtask

	// Random traffic in bursts: a state write followed by a run of ticks. Most
	// bursts are realistic (blink runs, button holds around the threshold); a
	// share is raw noise with any kind and any field value.
	task automatic run_bursts(input int unsigned budget);
		int unsigned start_count;
		int unsigned pick;
		int unsigned len;
		int unsigned eff;
		logic [MODE_W-1:0] ns;
		start_count = items_sent;
		eff = (press_limit == '0) ? 1 : press_limit;
		while (items_sent - start_count < budget) begin
			pick = $urandom_range(99);
			if (pick < 8)
				ns = MODE_W'($urandom_range(15, 12));
			else if (pick < 22)
				ns = MODE_GOT_IP;
			else
				ns = MODE_W'($urandom_range(11));
			send_state(ns);
			case ($urandom_range(2))
				0: begin
					len = $urandom_range(30, 1);
					repeat (len) send_tick(1'($urandom_range(1)));
				end
				1: hold_button($urandom_range(eff + 3, 1));
				default: begin
					len = $urandom_range(6, 1);
					repeat (len)
						send_item(1'($urandom_range(1)), MODE_W'($urandom_range(15)),
							1'($urandom_range(1)));
				end
			endcase
		end
	endtask

	initial begin
		int unsigned s;

		// Reset asserted at start, released on a rising edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender light, receiver heavy.
		sender_idle_pct = 27;
		receiver_idle_pct = 70;

		// Directed: every state followed by one tick (got-IP advances to
		// MQTT-connecting), then unknown codes that must leave the state alone.
		for (s = 0; s <= MODE_ERROR; s++) begin
			send_state(MODE_W'(s));
			send_tick(1'b0);
		end
		send_state(4'd12);
		send_state(4'd15);
		send_tick(1'b0);

		// Default threshold of 60.
		run_bursts(150);

		// Zero threshold behaves like one.
		write_threshold(8'd0);
		run_bursts(130);

		// Sender heavy, receiver light.
		sender_idle_pct = 70;
		receiver_idle_pct = 27;
		write_threshold(8'd1);
		run_bursts(130);

		// Largest threshold; a hold past 255 ticks runs the hold counter into
		// saturation with the request still raised.
		write_threshold(8'd255);
		hold_button(260);
		run_bursts(130);

		// No idling on either side.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_threshold(8'($urandom_range(254, 2)));
		// Long receiver hold-off while the sender keeps offering ticks.
		rx_hold_request = HOLDOFF_LEN;
		repeat (40) send_tick(1'($urandom_range(1)));
		run_bursts(150);
		// Sender pauses until every result is out, then resumes.
		wait_drained();
		run_bursts(50);

		write_threshold(8'd3);
		run_bursts(110);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (led_check.mismatches == 0 && led_check.outstanding() == 0)
			$display("** status_led_pattern_sequencer_core: PASSED **");
		else
			$display("** status_led_pattern_sequencer_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
